// File: rtl/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared types and constants of the two-way ranging time-of-flight block.
// ----------------------------------------------------------------------------
package dstwr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;
  localparam int QUO_BITS    = 32;

  localparam logic [QUO_BITS-1:0] TOF_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [QUO_BITS-1:0] TOF_NEG_MAG = 32'h8000_0000;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/dstwr_front.sv
// ----------------------------------------------------------------------------
// dstwr_front
// Accepts one exchange, forms the four intervals and their sum.
// ----------------------------------------------------------------------------
module dstwr_front #(
  parameter int STAMP_BITS = 32
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   tag_poll_tx_i,
  input  logic [31:0]                   tag_resp_rx_i,
  input  logic [31:0]                   tag_final_tx_i,
  input  logic [31:0]                   anchor_poll_rx_i,
  input  logic [31:0]                   anchor_resp_tx_i,
  input  logic [31:0]                   anchor_final_rx_i,
  input  dstwr_pkg::q_stat_t            q_stat_i,
  output logic                          push_o,
  output logic [5*STAMP_BITS+1:0]       push_data_o
);
  import dstwr_pkg::*;

  localparam int W  = STAMP_BITS;
  localparam int DW = STAMP_BITS + 2;

  logic [W-1:0]  t_poll, t_resp, t_final, a_poll, a_resp, a_final;
  logic [W-1:0]  ra, rb, da, db;
  logic [DW-1:0] div;

  assign t_poll  = W'(tag_poll_tx_i);
  assign t_resp  = W'(tag_resp_rx_i);
  assign t_final = W'(tag_final_tx_i);
  assign a_poll  = W'(anchor_poll_rx_i);
  assign a_resp  = W'(anchor_resp_tx_i);
  assign a_final = W'(anchor_final_rx_i);

  assign ra  = t_resp - t_poll;
  assign rb  = a_final - a_resp;
  assign da  = t_final - t_resp;
  assign db  = a_resp - a_poll;
  assign div = DW'(ra) + DW'(rb) + DW'(da) + DW'(db);

  assign in_stall_o  = q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;
  assign push_data_o = {ra, rb, da, db, div};

endmodule

// File: rtl/dstwr_queue.sv
// ----------------------------------------------------------------------------
// dstwr_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module dstwr_queue #(
  parameter int DATA_BITS = 162
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] push_data_i,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] pop_data_o,
  output dstwr_pkg::q_stat_t   q_stat_o
);
  import dstwr_pkg::*;

  logic [DATA_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/dstwr_back.sv
// ----------------------------------------------------------------------------
// dstwr_back
// Split multipliers, difference, and a bit-per-stage pipelined divider.
// ----------------------------------------------------------------------------
module dstwr_back #(
  parameter int STAMP_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dstwr_pkg::q_stat_t      q_stat_i,
  input  logic [5*STAMP_BITS+1:0] pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      tof_ticks_o,
  output logic                    zero_divisor_o
);
  import dstwr_pkg::*;

  localparam int W  = STAMP_BITS;
  localparam int DW = STAMP_BITS + 2;
  localparam int MW = 2 * STAMP_BITS;
  localparam int H  = (STAMP_BITS + 1) / 2;
  localparam int L  = STAMP_BITS - H;
  localparam int NS = QUO_BITS;

  logic en;
  logic [W-1:0]  ra, rb, da, db;
  logic [DW-1:0] div_in;

  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !q_stat_i.empty;
  assign {ra, rb, da, db, div_in} = pop_data_i;

  // Stage 1: partial products.
  logic          v1_q;
  logic [2*H-1:0] pll_q, qll_q;
  logic [H+L-1:0] plh_q, phl_q, qlh_q, qhl_q;
  logic [2*L-1:0] phh_q, qhh_q;
  logic [DW-1:0]  div1_q;

  // Stage 2: full products.
  logic          v2_q;
  logic [MW-1:0] p2_q, q2_q;
  logic [DW-1:0] div2_q;

  // Stage 3: magnitude of the difference.
  logic          v3_q, neg3_q;
  logic [MW-1:0] mag3_q;
  logic [DW-1:0] div3_q;

  // Divider stages.
  logic                vd_q   [NS+1];
  logic                negd_q [NS+1];
  logic                ovfd_q [NS+1];
  logic                zerod_q[NS+1];
  logic [DW-1:0]       divd_q [NS+1];
  logic [DW-1:0]       remd_q [NS+1];
  logic [QUO_BITS-1:0] lowd_q [NS+1];
  logic [QUO_BITS-1:0] quod_q [NS+1];

  logic [MW+QUO_BITS-1:0] magx;
  logic [MW-1:0]          mag_hi;
  assign magx   = {{QUO_BITS{1'b0}}, mag3_q};
  assign mag_hi = magx[MW+QUO_BITS-1:QUO_BITS];

  logic [DW:0]   trial  [NS];
  logic          take   [NS];
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      trial[k] = {remd_q[k], lowd_q[k][QUO_BITS-1]};
      take[k]  = trial[k] >= {1'b0, divd_q[k]};
    end
  end

  logic [QUO_BITS-1:0] lim, sat, res;
  always_comb begin
    lim = negd_q[NS] ? TOF_NEG_MAG : TOF_POS_MAX;
    sat = (ovfd_q[NS] || quod_q[NS] > lim) ? lim : quod_q[NS];
    res = negd_q[NS] ? (QUO_BITS'(0) - sat) : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k <= NS; k++) vd_q[k] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q  <= !q_stat_i.empty;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vd_q[0] <= v3_q;
      for (int k = 0; k < NS; k++) vd_q[k+1] <= vd_q[k];
      out_valid_o <= vd_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pll_q  <= (2*H)'(ra[H-1:0]) * (2*H)'(rb[H-1:0]);
      plh_q  <= (H+L)'(ra[H-1:0]) * (H+L)'(rb[W-1:H]);
      phl_q  <= (H+L)'(ra[W-1:H]) * (H+L)'(rb[H-1:0]);
      phh_q  <= (2*L)'(ra[W-1:H]) * (2*L)'(rb[W-1:H]);
      qll_q  <= (2*H)'(da[H-1:0]) * (2*H)'(db[H-1:0]);
      qlh_q  <= (H+L)'(da[H-1:0]) * (H+L)'(db[W-1:H]);
      qhl_q  <= (H+L)'(da[W-1:H]) * (H+L)'(db[H-1:0]);
      qhh_q  <= (2*L)'(da[W-1:H]) * (2*L)'(db[W-1:H]);
      div1_q <= div_in;

      p2_q   <= MW'(pll_q) + (MW'(plh_q) << H) + (MW'(phl_q) << H) + (MW'(phh_q) << (2*H));
      q2_q   <= MW'(qll_q) + (MW'(qlh_q) << H) + (MW'(qhl_q) << H) + (MW'(qhh_q) << (2*H));
      div2_q <= div1_q;

      neg3_q <= p2_q < q2_q;
      mag3_q <= (p2_q < q2_q) ? (q2_q - p2_q) : (p2_q - q2_q);
      div3_q <= div2_q;

      negd_q[0]  <= neg3_q;
      zerod_q[0] <= (div3_q == '0);
      ovfd_q[0]  <= mag_hi >= MW'(div3_q);
      divd_q[0]  <= div3_q;
      remd_q[0]  <= mag_hi[DW-1:0];
      lowd_q[0]  <= magx[QUO_BITS-1:0];
      quod_q[0]  <= '0;
      for (int k = 0; k < NS; k++) begin
        negd_q[k+1]  <= negd_q[k];
        zerod_q[k+1] <= zerod_q[k];
        ovfd_q[k+1]  <= ovfd_q[k];
        divd_q[k+1]  <= divd_q[k];
        remd_q[k+1]  <= take[k] ? DW'(trial[k] - {1'b0, divd_q[k]}) : trial[k][DW-1:0];
        lowd_q[k+1]  <= {lowd_q[k][QUO_BITS-2:0], 1'b0};
        quod_q[k+1]  <= {quod_q[k][QUO_BITS-2:0], take[k]};
      end

      tof_ticks_o    <= zerod_q[NS] ? '0 : $signed(res);
      zero_divisor_o <= zerod_q[NS];
    end
  end

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> tof_ticks_o == 0)
    else $error("zero divisor with nonzero result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vd_q[NS]) && $stable(v1_q))
    else $error("pipeline moved while stalled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_stat_i.empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/ds_twr_time_of_flight.sv
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight
// Time of flight of a double-sided two-way ranging exchange in device ticks.
// ----------------------------------------------------------------------------
// A request passes the queue register, three multiply and difference stages,
// 32 divider stages and the output register. Throughput is one request per
// cycle unless stalled, set by the fully pipelined divider. An output stall
// on a valid result freezes the whole back pipeline; the queue absorbs four
// requests. Reset clears all valid and queue state asynchronously.
module ds_twr_time_of_flight #(
  parameter int STAMP_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        tag_poll_tx_i,
  input  logic [31:0]        tag_resp_rx_i,
  input  logic [31:0]        tag_final_tx_i,
  input  logic [31:0]        anchor_poll_rx_i,
  input  logic [31:0]        anchor_resp_tx_i,
  input  logic [31:0]        anchor_final_rx_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] tof_ticks_o,
  output logic               zero_divisor_o
);
  import dstwr_pkg::*;

  localparam int QW = 5 * STAMP_BITS + 2;

  q_stat_t        q_stat;
  logic           push, pop;
  logic [QW-1:0]  push_data, pop_data;

  dstwr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .tag_poll_tx_i     (tag_poll_tx_i),
    .tag_resp_rx_i     (tag_resp_rx_i),
    .tag_final_tx_i    (tag_final_tx_i),
    .anchor_poll_rx_i  (anchor_poll_rx_i),
    .anchor_resp_tx_i  (anchor_resp_tx_i),
    .anchor_final_rx_i (anchor_final_rx_i),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  dstwr_queue #(.DATA_BITS(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  dstwr_back #(.STAMP_BITS(STAMP_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tof_ticks_o    (tof_ticks_o),
    .zero_divisor_o (zero_divisor_o)
  );

endmodule
